### design/bmw_pkg.sv
package bmw_pkg;

    // register map, one 32-bit register every 4 bytes
    typedef enum logic [1:0] {
        REG_MODE   = 2'd0,
        REG_RADIUS = 2'd1,
        REG_WIDTH  = 2'd2,
        REG_HEIGHT = 2'd3
    } reg_index_t;

    localparam int unsigned ADDR_W   = 4;
    localparam int unsigned DATA_W   = 32;

    localparam int unsigned RADIUS_W = 2;
    localparam int unsigned SIZE_W   = 12;
    localparam int unsigned COORD_W  = 11;

    localparam int unsigned MAX_HEIGHT = 2048;

    localparam logic                MODE_RESET   = 1'b0;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 2'd1;
    localparam logic [SIZE_W-1:0]   WIDTH_RESET  = 12'd640;
    localparam logic [SIZE_W-1:0]   HEIGHT_RESET = 12'd480;

endpackage

### design/bmw_line_ram.sv
module bmw_line_ram #(
    parameter int unsigned DEPTH = 2048,
    parameter int unsigned WIDTH = 6
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write-first: a read of the address being written sees the new data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata_reg <= wdata;
            end
            else
            begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/bmw_position.sv
module bmw_position #(
    parameter int unsigned MAX_WIDTH = 2048
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic                         frame_start,
    input  logic [bmw_pkg::SIZE_W-1:0]   frame_width,
    input  logic [bmw_pkg::SIZE_W-1:0]   frame_height,
    output logic [$clog2(MAX_WIDTH)-1:0] x,
    output logic [bmw_pkg::COORD_W-1:0]  y
);

    import bmw_pkg::*;

    localparam int unsigned XW = $clog2(MAX_WIDTH);
    localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

    logic [XW-1:0]      col_count_reg;
    logic [XW-1:0]      col_count_next;
    logic [COORD_W-1:0] row_count_reg;
    logic [COORD_W-1:0] row_count_next;

    logic [WW-1:0]      w;
    logic [SIZE_W-1:0]  h;
    logic [XW-1:0]      cc;
    logic [COORD_W-1:0] rc;
    logic [COORD_W:0]   y_tmp;
    logic [WW-1:0]      x_inc;
    logic [COORD_W:0]   y_inc;

    always_comb
    begin
        // clamp the frame size: zero counts as one, the width to what the line store holds, the height to MAX_HEIGHT
        if (frame_width == '0)
        begin
            w = WW'(1);
        end
        else if (32'(frame_width) > 32'(MAX_WIDTH))
        begin
            w = WW'(MAX_WIDTH);
        end
        else
        begin
            w = WW'(frame_width);
        end

        if (frame_height == '0)
        begin
            h = SIZE_W'(1);
        end
        else if (32'(frame_height) > 32'(MAX_HEIGHT))
        begin
            h = SIZE_W'(MAX_HEIGHT);
        end
        else
        begin
            h = frame_height;
        end

        cc = frame_start ? '0 : col_count_reg;
        rc = frame_start ? '0 : row_count_reg;

        // position left past a shrunken size wraps
        if (32'(cc) >= 32'(w))
        begin
            x     = '0;
            y_tmp = {1'b0, rc} + 1'b1;
        end
        else
        begin
            x     = cc;
            y_tmp = {1'b0, rc};
        end

        if (32'(y_tmp) >= 32'(h))
        begin
            y = '0;
        end
        else
        begin
            y = y_tmp[COORD_W-1:0];
        end

        x_inc = WW'(x) + 1'b1;
        y_inc = {1'b0, y} + 1'b1;
        if (x_inc >= w)
        begin
            col_count_next = '0;
            row_count_next = (32'(y_inc) >= 32'(h)) ? '0 : y_inc[COORD_W-1:0];
        end
        else
        begin
            col_count_next = x_inc[XW-1:0];
            row_count_next = y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (accept)
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

endmodule

### design/bmw_window.sv
module bmw_window #(
    parameter int unsigned MAX_RADIUS = 3,
    parameter int unsigned XW         = 11
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               shift,
    input  logic [2*MAX_RADIUS:0]              column,
    input  logic [XW-1:0]                      x,
    input  logic [bmw_pkg::COORD_W-1:0]        y,
    input  logic                               mode,
    input  logic [$clog2(MAX_RADIUS+1)-1:0]    radius,
    output logic                               result_pixel,
    output logic [bmw_pkg::COORD_W-1:0]        centre_x,
    output logic [bmw_pkg::COORD_W-1:0]        centre_y,
    output logic                               result_valid
);

    import bmw_pkg::*;

    localparam int unsigned SIDE = 2 * MAX_RADIUS + 1;
    localparam int unsigned RW   = $clog2(MAX_RADIUS + 1);

    // [column age][row age], column 0 newest, row 0 the arriving line
    logic [SIDE-1:0][SIDE-1:0] win_reg;
    logic [SIDE-1:0][SIDE-1:0] win_next;

    logic [RW:0]          span;
    logic                 any_set;
    logic                 all_set;
    logic                 inner;
    logic [XW-1:0]        cx_full;
    logic [XW+COORD_W-1:0] cx_wide;

    always_comb
    begin
        win_next[0] = column;
        for (int c = 1; c < SIDE; c++)
        begin
            win_next[c] = win_reg[c-1];
        end

        span    = {radius, 1'b0};
        any_set = 1'b0;
        all_set = 1'b1;
        for (int c = 0; c < SIDE; c++)
        begin
            for (int k = 0; k < SIDE; k++)
            begin
                // neighbours only: inside the window and not the centre
                if ((c <= int'(span)) && (k <= int'(span))
                    && !((c == int'(radius)) && (k == int'(radius))))
                begin
                    if (win_next[c][k])
                    begin
                        any_set = 1'b1;
                    end
                    else
                    begin
                        all_set = 1'b0;
                    end
                end
            end
        end

        result_valid = (32'(x) >= 32'(radius)) && (32'(y) >= 32'(radius));
        inner        = (32'(x) >= 32'(span)) && (32'(y) >= 32'(span));

        cx_full = x - XW'(radius);
        cx_wide = {{COORD_W{1'b0}}, cx_full};

        if (result_valid)
        begin
            centre_x     = cx_wide[COORD_W-1:0];
            centre_y     = y - COORD_W'(radius);
            result_pixel = inner & (mode ? all_set : any_set);
        end
        else
        begin
            centre_x     = '0;
            centre_y     = '0;
            result_pixel = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (shift)
        begin
            win_reg <= win_next;
        end
    end

endmodule

### design/binary_morphology_window.sv
// binary erosion / dilation over a square window on a raster stream of 1-bit pixels
//
// src channel: one pixel word per handshake (pixel, frame_start); frame_start
// marks column 0, row 0 of a new image. dst channel: one result word per
// accepted pixel, for the window centre radius columns and rows behind it.
// result_valid is low while that centre lies before the image origin.
// mode 0 gives one if any neighbour is set, mode 1 only if all are set;
// centres within radius of the top or left border give zero.
//
// a word accepted is captured in the read stage registers, then its window result
// in the output register that drives dst. throughput: one word per cycle unless dst
// stalls; the line store reads the new column, writes the prior one, on two ports.
// a stall on dst holds the output register and drops src_ready combinationally;
// the read stage and the window freeze with it, nothing is lost.
// reset clears the configuration to defaults, the window and the position
// counters; the line store is not cleared and needs no clearing pass, since
// stale entries only reach border results.
// configuration sits on an APB port, registers at 0x0 mode, 0x4 radius,
// 0x8 frame_width, 0xc frame_height; write only while the block is idle.
module binary_morphology_window #(
    parameter int unsigned MAX_WIDTH  = 2048,
    parameter int unsigned MAX_RADIUS = 3
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bmw_pkg::ADDR_W-1:0]   paddr,
    input  logic [bmw_pkg::DATA_W-1:0]   pwdata,
    output logic [bmw_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    // pixel stream in
    input  logic                         src_valid,
    output logic                         src_ready,
    input  logic                         pixel,
    input  logic                         frame_start,
    // result stream out
    output logic                         dst_valid,
    input  logic                         dst_ready,
    output logic                         result_pixel,
    output logic [bmw_pkg::COORD_W-1:0]  centre_x,
    output logic [bmw_pkg::COORD_W-1:0]  centre_y,
    output logic                         result_valid
);

    import bmw_pkg::*;

    localparam int unsigned XW    = $clog2(MAX_WIDTH);
    localparam int unsigned RW    = $clog2(MAX_RADIUS + 1);
    localparam int unsigned LINES = 2 * MAX_RADIUS;

    // configuration registers
    logic                mode_reg;
    logic [RADIUS_W-1:0] radius_reg;
    logic [SIZE_W-1:0]   frame_width_reg;
    logic [SIZE_W-1:0]   frame_height_reg;
    logic                cfg_write;
    reg_index_t          cfg_sel;
    logic [RW-1:0]       radius_eff;

    // handshake
    logic stall;
    logic accept;

    // read stage
    logic [XW-1:0]      pos_x;
    logic [COORD_W-1:0] pos_y;
    logic               s1_valid_reg;
    logic               s1_pixel_reg;
    logic [XW-1:0]      s1_x_reg;
    logic [COORD_W-1:0] s1_y_reg;
    logic [LINES-1:0]   line_bits;
    logic [LINES-1:0]   line_wdata;
    logic               shift;

    // window evaluation
    logic               win_result;
    logic [COORD_W-1:0] win_cx;
    logic [COORD_W-1:0] win_cy;
    logic               win_valid;

    // output register
    logic               dst_valid_reg;
    logic               result_pixel_reg;
    logic [COORD_W-1:0] centre_x_reg;
    logic [COORD_W-1:0] centre_y_reg;
    logic               result_valid_reg;

    // ---------------- configuration port ----------------

    assign pready    = 1'b1;
    assign cfg_sel   = reg_index_t'(paddr[ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_RESET;
            radius_reg       <= RADIUS_RESET;
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_MODE:   mode_reg         <= pwdata[0];
                REG_RADIUS: radius_reg       <= pwdata[RADIUS_W-1:0];
                REG_WIDTH:  frame_width_reg  <= pwdata[SIZE_W-1:0];
                REG_HEIGHT: frame_height_reg <= pwdata[SIZE_W-1:0];
                default:    mode_reg         <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_MODE:   prdata = DATA_W'(mode_reg);
            REG_RADIUS: prdata = DATA_W'(radius_reg);
            REG_WIDTH:  prdata = DATA_W'(frame_width_reg);
            REG_HEIGHT: prdata = DATA_W'(frame_height_reg);
            default:    prdata = '0;
        endcase
    end

    // radius beyond what the window holds saturates
    always_comb
    begin
        if (32'(radius_reg) > 32'(MAX_RADIUS))
        begin
            radius_eff = RW'(MAX_RADIUS);
        end
        else
        begin
            radius_eff = RW'(radius_reg);
        end
    end

    // ---------------- handshake ----------------

    // the whole pipe moves unless a finished word waits on dst
    assign stall     = dst_valid_reg && !dst_ready;
    assign src_ready = !stall;
    assign accept    = src_valid && src_ready;
    assign shift     = !stall && s1_valid_reg;

    // ---------------- position and line store read ----------------

    bmw_position #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_position (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .frame_start  (frame_start),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .x            (pos_x),
        .y            (pos_y)
    );

    // each line store row is one column: line k holds the pixel k+1 rows up
    assign line_wdata = {line_bits[LINES-2:0], s1_pixel_reg};

    bmw_line_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (LINES)
    ) u_line_ram (
        .clk   (clk),
        .we    (shift),
        .waddr (s1_x_reg),
        .wdata (line_wdata),
        .re    (accept),
        .raddr (pos_x),
        .rdata (line_bits)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            s1_valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= pixel;
            s1_x_reg     <= pos_x;
            s1_y_reg     <= pos_y;
        end
    end

    // ---------------- window shift and evaluation ----------------

    bmw_window #(
        .MAX_RADIUS (MAX_RADIUS),
        .XW         (XW)
    ) u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .shift        (shift),
        .column       ({line_bits, s1_pixel_reg}),
        .x            (s1_x_reg),
        .y            (s1_y_reg),
        .mode         (mode_reg),
        .radius       (radius_eff),
        .result_pixel (win_result),
        .centre_x     (win_cx),
        .centre_y     (win_cy),
        .result_valid (win_valid)
    );

    // ---------------- output register ----------------

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dst_valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            dst_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            result_pixel_reg <= win_result;
            centre_x_reg     <= win_cx;
            centre_y_reg     <= win_cy;
            result_valid_reg <= win_valid;
        end
    end

    assign dst_valid    = dst_valid_reg;
    assign result_pixel = result_pixel_reg;
    assign centre_x     = centre_x_reg;
    assign centre_y     = centre_y_reg;
    assign result_valid = result_valid_reg;

endmodule
